>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the number increment block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TNI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TNI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tni_pkg.sv
// ----------------------------------------------------------------------------
// tni_pkg
// Types, constants and helper functions of the number increment block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tni_pkg;

    // Line storage geometry.
    localparam int LINE_MAX   = 4096;
    localparam int LINE_AW    = $clog2(LINE_MAX);
    localparam int COL_W      = LINE_AW + 1;
    localparam int MAX_DIGITS = 64;

    // Character codes.
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [15:0] CH_LX    = 16'h0078;
    localparam logic [15:0] CH_UX    = 16'h0058;
    localparam logic [15:0] CH_LB    = 16'h0062;
    localparam logic [15:0] CH_UB    = 16'h0042;
    localparam logic [4:0]  UV_NONE  = 5'd16;

    // Prefix kinds.
    localparam logic [2:0] PK_NONE = 3'd0;
    localparam logic [2:0] PK_LX   = 3'd1;
    localparam logic [2:0] PK_UX   = 3'd2;
    localparam logic [2:0] PK_LB   = 3'd3;
    localparam logic [2:0] PK_UB   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CURSOR = 2'd0;
    localparam logic [1:0] CFG_DELTA  = 2'd1;
    localparam logic [1:0] CFG_SUB    = 2'd2;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_BIN
    } t_base;

    typedef enum logic [1:0] {
        ALU_MAC,
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        t_base   base;
    } t_alu_ctrl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIME,
        S_SEARCH,
        S_START,
        S_SKIP,
        S_DIGITS,
        S_ARITH,
        S_SUB2,
        S_SIGN,
        S_BCD,
        S_LEAD,
        S_EMIT,
        S_NONE
    } t_state;

    // Digit value of a unit in any base, UV_NONE if it is no digit.
    function automatic logic [4:0] unit_value(input logic [15:0] u);
        logic [4:0] v;
        v = UV_NONE;
        if (u >= 16'h0030 && u <= 16'h0039) v = 5'(u - 16'h0030);
        else if (u >= 16'h0061 && u <= 16'h0066) v = 5'(u - 16'h0057);
        else if (u >= 16'h0041 && u <= 16'h0046) v = 5'(u - 16'h0037);
        return v;
    endfunction

    function automatic logic is_dec(input logic [15:0] u);
        return (u >= 16'h0030) && (u <= 16'h0039);
    endfunction

endpackage

>>> sv/tni_alu.sv
// ----------------------------------------------------------------------------
// tni_alu
// Shared arithmetic unit: saturating digit accumulate, saturating add and
// subtract with borrow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tni_alu (
    input  tni_pkg::t_alu_ctrl i_ctrl,
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_b,
    input  logic [3:0]         i_d,
    output logic [63:0]        o_res,
    output logic               o_borrow
);
    import tni_pkg::*;

    logic [67:0] w_scaled;
    logic [67:0] w_mac;
    logic [64:0] w_sum;

    always_comb begin
        w_scaled = '0;
        w_mac    = '0;
        w_sum    = '0;
        o_res    = '0;
        o_borrow = 1'b0;
        case (i_ctrl.op)
            ALU_MAC: begin
                // Value times base plus digit; anything past 64 bits saturates.
                case (i_ctrl.base)
                    BASE_HEX: w_scaled = {i_a, 4'b0000};
                    BASE_BIN: w_scaled = {3'b000, i_a, 1'b0};
                    default:  w_scaled = {1'b0, i_a, 3'b000} + {3'b000, i_a, 1'b0};
                endcase
                w_mac = w_scaled + {64'd0, i_d};
                o_res = (w_mac[67:64] != 4'd0) ? {64{1'b1}} : w_mac[63:0];
            end
            ALU_ADD: begin
                w_sum = {1'b0, i_a} + {1'b0, i_b};
                o_res = w_sum[64] ? {64{1'b1}} : w_sum[63:0];
            end
            ALU_SUB: begin
                w_sum    = {1'b0, i_a} - {1'b0, i_b};
                o_res    = w_sum[63:0];
                o_borrow = w_sum[64];
            end
            default: o_res = '0;
        endcase
    end

endmodule

>>> sv/tni_bcd.sv
// ----------------------------------------------------------------------------
// tni_bcd
// Iterative binary to BCD converter, one input bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tni_bcd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_bin,
    output logic        o_done,
    output logic [79:0] o_bcd
);
    import tni_pkg::*;

    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_bin, n_bin;
    logic [79:0] r_bcd, n_bcd;
    logic        r_done, n_done;
    logic [79:0] w_adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < 20; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd64;
            n_bin  = i_bin;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bcd = {w_adj[78:0], r_bin[63]};
            n_bin = {r_bin[62:0], 1'b0};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

>>> sv/text_number_increment_top.sv
// ----------------------------------------------------------------------------
// text_number_increment_top
// Stores a line of UTF-16 units, then finds the first number token that ends
// past the cursor, adds or subtracts delta and emits the new digits.
//
//  Channel  Handshake                 Payload
//  input    i_valid / o_stall         i_char_in, i_last_char
//  output   o_valid / i_stall         o_found ... o_last_out
//  config   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Mid-line units are taken one per cycle into the line memory.
// After the final unit the priming states load a three-unit window, then the
// scanner steps one unit per memory read, with S_START, and S_SKIP for a
// prefix, at each token start. The shared ALU works in S_ARITH, with a second
// pass in S_SUB2 when a subtraction passes zero, and S_SIGN then settles the
// sign. A decimal result passes through the BCD converter, then the leading
// digit search runs, and one digit is emitted per cycle when not stalled.
// The input is stalled from the final unit until the last digit is loaded.
// Reset is synchronous, active low; the line memory needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_number_increment_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_char_in,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [11:0] o_token_start,
    output logic [12:0] o_token_end,
    output logic        o_negative_out,
    output logic [2:0]  o_prefix_kind,
    output logic [6:0]  o_digit_char,
    output logic        o_width_capped,
    output logic        o_last_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import tni_pkg::*;

    // Line memory.
    logic [15:0] r_mem [LINE_MAX];
    logic [15:0] r_rd;
    logic [LINE_AW-1:0] w_raddr;
    logic        w_we;

    // Configuration.
    logic [11:0] r_cursor;
    logic [63:0] r_delta;
    logic        r_sub;

    // Sequencer state.
    t_state      r_state, n_state;
    logic        r_wait, n_wait;
    logic [5:0]  r_cnt, n_cnt;
    logic [COL_W-1:0] r_col, n_col;
    logic [COL_W-1:0] r_len, n_len;
    logic [COL_W-1:0] r_pos, n_pos;
    logic [15:0] r_w0, n_w0, r_w1, n_w1, r_w2, n_w2;
    logic [11:0] r_ts, n_ts;
    logic [COL_W-1:0] r_ds, n_ds, r_end, n_end;
    logic [63:0] r_mag, n_mag;
    t_base       r_base, n_base;
    logic [2:0]  r_pk, n_pk;
    logic        r_neg, n_neg, r_up, n_up, r_cap, n_cap;
    logic [5:0]  r_idx, n_idx;

    // Output register.
    logic        r_ovalid, n_ovalid;
    logic        r_ofound, n_ofound;
    logic [11:0] r_ots, n_ots;
    logic [12:0] r_ote, n_ote;
    logic        r_oneg, n_oneg;
    logic [2:0]  r_opk, n_opk;
    logic [6:0]  r_och, n_och;
    logic        r_ocap, n_ocap;
    logic        r_olast, n_olast;

    // Shared units.
    t_alu_ctrl   w_alu_ctrl;
    logic [63:0] w_alu_a, w_alu_b, w_alu_res;
    logic [3:0]  w_alu_d;
    logic        w_alu_borrow;
    logic        w_bcd_start, w_bcd_done;
    logic [79:0] w_bcd;

    logic        w_in_acc, w_out_free;
    logic        w_v0, w_v1, w_v2;
    logic [4:0]  w_uv0, w_uv2, w_base_val;
    logic [COL_W-1:0] w_req, w_width;
    logic [5:0]  w_dsel;
    logic [3:0]  w_digit;
    logic [6:0]  w_char;
    logic [6:0]  w_n, w_minw, w_total;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;

    tni_alu u_alu (
        .i_ctrl   (w_alu_ctrl),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .i_d      (w_alu_d),
        .o_res    (w_alu_res),
        .o_borrow (w_alu_borrow)
    );

    tni_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bcd_start),
        .i_bin   (r_mag),
        .o_done  (w_bcd_done),
        .o_bcd   (w_bcd)
    );

    // Line memory: written by accepted units, read by the scanner.
    assign w_we = w_in_acc && (r_col < COL_W'(LINE_MAX));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_col[LINE_AW-1:0]] <= i_char_in;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Configuration writes.
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_delta  <= 64'd1;
            r_sub    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CURSOR: r_cursor <= i_cfg_data[11:0];
                CFG_DELTA:  r_delta  <= i_cfg_data;
                CFG_SUB:    r_sub    <= i_cfg_data[0];
                default:    r_sub    <= r_sub;
            endcase
        end
    end

    // Window of three units at the scan position.
    assign w_v0  = r_pos < r_len;
    assign w_v1  = (r_pos + COL_W'(1)) < r_len;
    assign w_v2  = (r_pos + COL_W'(2)) < r_len;
    assign w_uv0 = unit_value(r_w0);
    assign w_uv2 = unit_value(r_w2);
    assign w_req = ({1'b0, r_cursor} < r_len) ? {1'b0, r_cursor} : r_len;
    assign w_width = r_end - r_ds;

    always_comb begin
        case (r_base)
            BASE_HEX: w_base_val = 5'd16;
            BASE_BIN: w_base_val = 5'd2;
            default:  w_base_val = 5'd10;
        endcase
    end

    // Digit of the result at a selected position, least significant is zero.
    assign w_dsel = (r_state == S_LEAD) ? r_idx : r_cnt;

    always_comb begin
        w_digit = 4'd0;
        case (r_base)
            BASE_HEX: if (w_dsel < 6'd16) w_digit = r_mag[{w_dsel[3:0], 2'b00} +: 4];
            BASE_BIN: w_digit = {3'b000, r_mag[w_dsel]};
            default:  if (w_dsel < 6'd20) w_digit = w_bcd[7'(w_dsel) * 7'd4 +: 4];
        endcase
        if (w_digit < 4'd10) w_char = 7'h30 + 7'(w_digit);
        else w_char = (r_up ? 7'h41 : 7'h61) + 7'(w_digit) - 7'd10;
    end

    // Digit count to emit: significant digits, padded to the original width, capped at MAX_DIGITS.
    assign w_n     = 7'(r_idx) + 7'd1;
    assign w_minw  = (w_width > COL_W'(MAX_DIGITS)) ? 7'(MAX_DIGITS) : 7'(w_width);
    assign w_total = (w_n > w_minw) ? w_n : w_minw;

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_wait   = 1'b0;
        n_cnt    = r_cnt;
        n_col    = r_col;
        n_len    = r_len;
        n_pos    = r_pos;
        n_w0     = r_w0;
        n_w1     = r_w1;
        n_w2     = r_w2;
        n_ts     = r_ts;
        n_ds     = r_ds;
        n_end    = r_end;
        n_mag    = r_mag;
        n_base   = r_base;
        n_pk     = r_pk;
        n_neg    = r_neg;
        n_up     = r_up;
        n_cap    = r_cap;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && i_stall;
        n_ofound = r_ofound;
        n_ots    = r_ots;
        n_ote    = r_ote;
        n_oneg   = r_oneg;
        n_opk    = r_opk;
        n_och    = r_och;
        n_ocap   = r_ocap;
        n_olast  = r_olast;
        w_raddr  = LINE_AW'(r_pos + COL_W'(3));
        w_bcd_start = 1'b0;
        w_alu_ctrl  = '{op: ALU_MAC, base: r_base};
        w_alu_a  = r_mag;
        w_alu_b  = r_delta;
        w_alu_d  = w_uv0[3:0];

        if (r_wait) begin
            // Fill the far end of the window after a step.
            n_w2 = r_rd;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        n_col = w_we ? r_col + COL_W'(1) : r_col;
                        if (i_last_char) begin
                            n_len   = n_col;
                            n_col   = '0;
                            n_cnt   = '0;
                            n_state = S_PRIME;
                        end
                    end
                end
                S_PRIME: begin
                    w_raddr = LINE_AW'(r_cnt[1:0]);
                    n_cnt   = r_cnt + 6'd1;
                    case (r_cnt[1:0])
                        2'd1: n_w0 = r_rd;
                        2'd2: n_w1 = r_rd;
                        2'd3: begin
                            n_w2    = r_rd;
                            n_pos   = '0;
                            n_state = S_SEARCH;
                        end
                        default: n_w0 = r_w0;
                    endcase
                end
                S_SEARCH: begin
                    if (!w_v0) begin
                        n_state = S_NONE;
                    end else if (r_w0 == CH_MINUS && w_v1 && is_dec(r_w1)) begin
                        n_ts    = r_pos[11:0];
                        n_neg   = 1'b1;
                        n_w0    = r_w1;
                        n_w1    = r_w2;
                        n_pos   = r_pos + COL_W'(1);
                        n_wait  = 1'b1;
                        n_state = S_START;
                    end else if (is_dec(r_w0)) begin
                        n_ts    = r_pos[11:0];
                        n_neg   = 1'b0;
                        n_state = S_START;
                    end else begin
                        n_w0   = r_w1;
                        n_w1   = r_w2;
                        n_pos  = r_pos + COL_W'(1);
                        n_wait = 1'b1;
                    end
                end
                S_START: begin
                    n_mag = '0;
                    n_up  = 1'b0;
                    if (r_w0 == CH_ZERO && w_v2 && (r_w1 == CH_LX || r_w1 == CH_UX)
                        && w_uv2 < 5'd16) begin
                        n_base  = BASE_HEX;
                        n_pk    = (r_w1 == CH_UX) ? PK_UX : PK_LX;
                        n_state = S_SKIP;
                    end else if (r_w0 == CH_ZERO && w_v2 && (r_w1 == CH_LB || r_w1 == CH_UB)
                                 && w_uv2 < 5'd2) begin
                        n_base  = BASE_BIN;
                        n_pk    = (r_w1 == CH_UB) ? PK_UB : PK_LB;
                        n_state = S_SKIP;
                    end else begin
                        n_base  = BASE_DEC;
                        n_pk    = PK_NONE;
                        n_ds    = r_pos;
                        n_state = S_DIGITS;
                    end
                    if (n_state == S_SKIP) begin
                        n_w0   = r_w1;
                        n_w1   = r_w2;
                        n_pos  = r_pos + COL_W'(1);
                        n_wait = 1'b1;
                    end
                end
                S_SKIP: begin
                    n_w0    = r_w1;
                    n_w1    = r_w2;
                    n_pos   = r_pos + COL_W'(1);
                    n_ds    = r_pos + COL_W'(1);
                    n_wait  = 1'b1;
                    n_state = S_DIGITS;
                end
                S_DIGITS: begin
                    if (w_v0 && w_uv0 < w_base_val) begin
                        n_mag  = w_alu_res;
                        n_up   = r_up || (r_w0 >= 16'h0041 && r_w0 <= 16'h0046);
                        n_w0   = r_w1;
                        n_w1   = r_w2;
                        n_pos  = r_pos + COL_W'(1);
                        n_wait = 1'b1;
                    end else begin
                        n_end   = r_pos;
                        n_state = (r_pos > w_req) ? S_ARITH : S_SEARCH;
                    end
                end
                S_ARITH: begin
                    if (r_sub == r_neg) begin
                        w_alu_ctrl = '{op: ALU_ADD, base: r_base};
                        n_mag      = w_alu_res;
                        n_state    = S_SIGN;
                    end else begin
                        w_alu_ctrl = '{op: ALU_SUB, base: r_base};
                        if (w_alu_borrow) begin
                            n_state = S_SUB2;
                        end else begin
                            n_mag   = w_alu_res;
                            n_state = S_SIGN;
                        end
                    end
                end
                S_SUB2: begin
                    // Magnitude passed zero: take delta minus value, flip sign.
                    w_alu_ctrl = '{op: ALU_SUB, base: r_base};
                    w_alu_a    = r_delta;
                    w_alu_b    = r_mag;
                    n_mag      = w_alu_res;
                    n_neg      = !r_neg;
                    n_state    = S_SIGN;
                end
                S_SIGN: begin
                    n_neg = r_neg && (r_mag != 64'd0);
                    case (r_base)
                        BASE_HEX: begin
                            n_idx   = 6'd15;
                            n_state = S_LEAD;
                        end
                        BASE_BIN: begin
                            n_idx   = 6'd63;
                            n_state = S_LEAD;
                        end
                        default: begin
                            w_bcd_start = 1'b1;
                            n_state     = S_BCD;
                        end
                    endcase
                end
                S_BCD: begin
                    if (w_bcd_done) begin
                        n_idx   = 6'd19;
                        n_state = S_LEAD;
                    end
                end
                S_LEAD: begin
                    if (r_idx != 6'd0 && w_digit == 4'd0) begin
                        n_idx = r_idx - 6'd1;
                    end else begin
                        n_cnt   = 6'(w_total - 7'd1);
                        n_cap   = w_width > COL_W'(MAX_DIGITS);
                        n_state = S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        n_ovalid = 1'b1;
                        n_ofound = 1'b1;
                        n_ots    = r_ts;
                        n_ote    = 13'(r_end);
                        n_oneg   = r_neg;
                        n_opk    = r_pk;
                        n_och    = (r_cnt > r_idx) ? 7'h30 : w_char;
                        n_ocap   = r_cap;
                        n_olast  = (r_cnt == 6'd0);
                        if (r_cnt == 6'd0) n_state = S_IDLE;
                        else n_cnt = r_cnt - 6'd1;
                    end
                end
                S_NONE: begin
                    if (w_out_free) begin
                        n_ovalid = 1'b1;
                        n_ofound = 1'b0;
                        n_ots    = '0;
                        n_ote    = '0;
                        n_oneg   = 1'b0;
                        n_opk    = PK_NONE;
                        n_och    = '0;
                        n_ocap   = 1'b0;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_col    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_col    <= n_col;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_pos    <= n_pos;
        r_w0     <= n_w0;
        r_w1     <= n_w1;
        r_w2     <= n_w2;
        r_ts     <= n_ts;
        r_ds     <= n_ds;
        r_end    <= n_end;
        r_mag    <= n_mag;
        r_base   <= n_base;
        r_pk     <= n_pk;
        r_neg    <= n_neg;
        r_up     <= n_up;
        r_cap    <= n_cap;
        r_idx    <= n_idx;
        r_ofound <= n_ofound;
        r_ots    <= n_ots;
        r_ote    <= n_ote;
        r_oneg   <= n_oneg;
        r_opk    <= n_opk;
        r_och    <= n_och;
        r_ocap   <= n_ocap;
        r_olast  <= n_olast;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_found        = r_ofound;
    assign o_token_start  = r_ots;
    assign o_token_end    = r_ote;
    assign o_negative_out = r_oneg;
    assign o_prefix_kind  = r_opk;
    assign o_digit_char   = r_och;
    assign o_width_capped = r_ocap;
    assign o_last_out     = r_olast;

endmodule

>>> sv/tni_checker.sv
// ----------------------------------------------------------------------------
// tni_checker
// Port-level checks of the number increment block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tni_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_found,
    input logic [11:0] o_token_start,
    input logic [12:0] o_token_end,
    input logic [6:0]  o_digit_char,
    input logic        o_last_out
);
    // A stalled item stays in place.
    `TNI_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_digit_char), "stalled item changed")

    // A missing token is reported in a single final item.
    `TNI_ASSERT_NOW(a_none_last, i_clk, i_rst_n, o_valid && !o_found, o_last_out, "no-token item is not final")

    // A missing token carries zero span and digit.
    `TNI_ASSERT_NOW(a_none_zero, i_clk, i_rst_n, o_valid && !o_found, o_token_end == 13'd0 && o_digit_char == 7'd0, "no-token item not cleared")

    // A found token has a nonempty span.
    `TNI_ASSERT_NOW(a_span, i_clk, i_rst_n, o_valid && o_found, o_token_end > {1'b0, o_token_start}, "token span is empty")

endmodule

bind text_number_increment_top tni_checker u_tni_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_found       (o_found),
    .o_token_start (o_token_start),
    .o_token_end   (o_token_end),
    .o_digit_char  (o_digit_char),
    .o_last_out    (o_last_out)
);
